// File: rtl/jerk_limited_command_limiter_assert.svh
// Assertion macros for the jerk limited command limiter.
// Included by the top level; needs no other file.
`ifndef JERK_LIMITED_COMMAND_LIMITER_ASSERT_SVH
`define JERK_LIMITED_COMMAND_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JLCL_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("jlcl: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JLCL_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("jlcl: assertion failed");

`endif

// File: rtl/jlcl_pkg.sv
// Package for the jerk limited command limiter: payload structs, register
// indexes, reset values, sequencer states and default widths. No dependencies.
package jlcl_pkg;

    localparam int DEFAULT_VALUE_WIDTH   = 32;
    localparam int DEFAULT_FRACTION_BITS = 16;

    // Width of one operand of the shared multiplier.
    localparam int MUL_W       = 32;
    localparam int IO_W        = 32;
    localparam int LIMIT_W     = 31;
    localparam int PERIOD_W    = 32;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAX_LINEAR_SPEED = 3'd0,
        CFG_MAX_YAW_RATE     = 3'd1,
        CFG_MAX_LINEAR_ACCEL = 3'd2,
        CFG_MAX_LINEAR_DECEL = 3'd3,
        CFG_MAX_YAW_ACCEL    = 3'd4,
        CFG_MAX_JERK         = 3'd5,
        CFG_STEP_PERIOD      = 3'd6,
        CFG_INVERSE_PERIOD   = 3'd7
    } cfg_index_t;

    localparam logic [LIMIT_W-1:0]  RST_MAX_LINEAR_SPEED = 31'd65536;
    localparam logic [LIMIT_W-1:0]  RST_MAX_YAW_RATE     = 31'd65536;
    localparam logic [LIMIT_W-1:0]  RST_MAX_LINEAR_ACCEL = 31'd65536;
    localparam logic [LIMIT_W-1:0]  RST_MAX_LINEAR_DECEL = 31'd65536;
    localparam logic [LIMIT_W-1:0]  RST_MAX_YAW_ACCEL    = 31'd65536;
    localparam logic [LIMIT_W-1:0]  RST_MAX_JERK         = 31'd655360;
    localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD      = 32'd42949673;
    localparam logic [LIMIT_W-1:0]  RST_INVERSE_PERIOD   = 31'd6553600;

    localparam logic FUNC_LIMIT = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JERK,
        ST_JSAVE,
        ST_PREP,
        ST_ELO,
        ST_EHI,
        ST_ESUM,
        ST_DESIRE,
        ST_ACCEL,
        ST_PLO,
        ST_PHI,
        ST_PSUM,
        ST_PROP,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                   func;
        logic signed [IO_W-1:0] linear_request;
        logic signed [IO_W-1:0] yaw_request;
    } in_item_t;

    typedef struct packed {
        logic signed [IO_W-1:0] linear_out;
        logic signed [IO_W-1:0] yaw_out;
    } out_item_t;

endpackage

// File: rtl/jerk_limited_command_limiter.sv
// Top level of the jerk limited command limiter: sequencer, shared multiplier
// and axis state. Uses jlcl_pkg and the jerk_limited_command_limiter_assert.svh macros.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in      | in        | in_valid / in_stall | in_data (func, linear/yaw request)
//   out     | out       | out_valid/out_stall | out_data (linear_out, yaw_out)
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A limit item's result is loaded into the output register after the jerk step,
// eleven steps per axis, then the output step, with each axis product formed as
// two 32 by 32 passes of one multiplier. A clear item, or any item while
// step_period is zero, takes fewer steps. A new item is taken in the cycle after
// the result is loaded, even while that result is still stalled, so no limit item
// is taken while the last is in work. Reset restores the register defaults and
// zeroes each axis value and acceleration; configuration is always ready.
`include "jerk_limited_command_limiter_assert.svh"

module jerk_limited_command_limiter
    import jlcl_pkg::*;
#(
    parameter int VALUE_WIDTH   = DEFAULT_VALUE_WIDTH,
    parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [IO_W-1:0]        cfg_data
);

    localparam int VW    = VALUE_WIDTH;
    localparam int XW    = ((VW > IO_W) ? VW : IO_W) + 3;
    localparam int MAG_W = VW + 1;
    localparam int PAD_W = 2 * MUL_W;
    localparam int ACC_W = 3 * MUL_W;
    localparam longint VAL_MAX_L = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint VAL_MIN_L = -VAL_MAX_L - 1;
    localparam logic signed [XW-1:0] VAL_MAX_X = XW'(VAL_MAX_L);
    localparam logic signed [XW-1:0] VAL_MIN_X = XW'(VAL_MIN_L);

    function automatic logic signed [VW-1:0] sat_val(input logic signed [XW-1:0] x);
        logic signed [VW-1:0] r;
        if (x > VAL_MAX_X)
            r = VW'(VAL_MAX_L);
        else if (x < VAL_MIN_X)
            r = VW'(VAL_MIN_L);
        else
            r = x[VW-1:0];
        return r;
    endfunction

    function automatic logic signed [XW-1:0] clamp_sym(input logic signed [XW-1:0] x,
                                                       input logic [LIMIT_W-1:0] lim);
        logic signed [XW-1:0] l;
        logic signed [XW-1:0] r;
        l = $signed(XW'(lim));
        if (x > l)
            r = l;
        else if (x < -l)
            r = -l;
        else
            r = x;
        return r;
    endfunction

    function automatic logic signed [XW-1:0] abs_x(input logic signed [XW-1:0] x);
        return (x < 0) ? -x : x;
    endfunction

    // Configuration registers.
    logic [LIMIT_W-1:0]  speed_lin_reg, speed_yaw_reg;
    logic [LIMIT_W-1:0]  accel_lin_reg, decel_lin_reg, accel_yaw_reg, jerk_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [LIMIT_W-1:0]  inv_reg;

    state_t state_reg, state_next;
    logic   ax_reg, ax_next;

    logic signed [VW-1:0] val_reg [2];
    logic signed [VW-1:0] val_next [2];
    logic signed [VW-1:0] accel_reg [2];
    logic signed [VW-1:0] accel_next [2];
    logic signed [VW-1:0] tgt_reg [2];
    logic signed [VW-1:0] tgt_next [2];

    logic signed [XW-1:0]    err_reg, err_next;
    logic [MAG_W-1:0]        emag_reg, emag_next;
    logic [LIMIT_W-1:0]      lim_reg, lim_next;
    logic [LIMIT_W-1:0]      jstep_reg, jstep_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [XW-1:0]    diff_reg, diff_next;
    logic signed [VW-1:0]    a_reg, a_next;
    logic [VW-1:0]           amag_reg, amag_next;
    logic signed [XW-1:0]    prop_reg, prop_next;
    logic [PAD_W-1:0]        mul_reg, mul_next;
    logic [MUL_W-1:0]        mul_a, mul_b;
    out_item_t               out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;

    // Datapath terms for the axis being worked on.
    logic signed [VW-1:0] cur_val, cur_acc, cur_tgt;
    logic signed [XW-1:0] lin_tgt_x, yaw_tgt_x;
    logic signed [XW-1:0] err_x, err_abs, t_abs, v_abs;
    logic                 speeding;
    logic [ACC_W-1:0]     dshift;
    logic [LIMIT_W-1:0]   dmag;
    logic signed [XW-1:0] d_pos, desired, delta, asum, a_abs, pmag, nerr;
    logic signed [VW-1:0] a_sat;
    logic [PAD_W-1:0]     emag_pad, amag_pad;
    logic                 snap;
    logic                 in_xfer;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cur_val = val_reg[ax_reg];
    assign cur_acc = accel_reg[ax_reg];
    assign cur_tgt = tgt_reg[ax_reg];

    assign lin_tgt_x = clamp_sym(XW'(sat_val(XW'(in_data.linear_request))), speed_lin_reg);
    assign yaw_tgt_x = clamp_sym(XW'(sat_val(XW'(in_data.yaw_request))), speed_yaw_reg);

    assign err_x    = XW'(cur_tgt) - XW'(cur_val);
    assign err_abs  = abs_x(err_x);
    assign t_abs    = abs_x(XW'(cur_tgt));
    assign v_abs    = abs_x(XW'(cur_val));
    assign speeding = (t_abs > v_abs) && ((cur_val == 0) || ((cur_tgt > 0) == (cur_val > 0)));

    // Requested acceleration: the error scaled by the inverse period, then clamped.
    assign dshift  = acc_reg >> FRACTION_BITS;
    assign dmag    = (dshift > ACC_W'(lim_reg)) ? lim_reg : dshift[LIMIT_W-1:0];
    assign d_pos   = $signed(XW'(dmag));
    assign desired = err_reg[XW-1] ? -d_pos : d_pos;

    assign delta = clamp_sym(diff_reg, jstep_reg);
    assign asum  = XW'(cur_acc) + delta;
    assign a_sat = sat_val(asum);
    assign a_abs = abs_x(XW'(a_sat));

    assign pmag = $signed(XW'(acc_reg >> MUL_W));
    assign nerr = XW'(cur_tgt) - prop_reg;
    assign snap = (err_reg == 0) || (nerr == 0) || ((err_reg > 0) && (nerr < 0))
                  || ((err_reg < 0) && (nerr > 0));

    assign emag_pad = PAD_W'(emag_reg);
    assign amag_pad = PAD_W'(amag_reg);
    assign mul_next = PAD_W'(mul_a) * PAD_W'(mul_b);

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        val_next       = val_reg;
        accel_next     = accel_reg;
        tgt_next       = tgt_reg;
        err_next       = err_reg;
        emag_next      = emag_reg;
        lim_next       = lim_reg;
        jstep_next     = jstep_reg;
        acc_next       = acc_reg;
        diff_next      = diff_reg;
        a_next         = a_reg;
        amag_next      = amag_reg;
        prop_next      = prop_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.func == FUNC_CLEAR)
                    begin
                        val_next   = '{default: '0};
                        accel_next = '{default: '0};
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        tgt_next[0] = lin_tgt_x[VW-1:0];
                        tgt_next[1] = yaw_tgt_x[VW-1:0];
                        state_next  = ST_JERK;
                    end
                end
            end
            ST_JERK:
            begin
                mul_a      = MUL_W'(jerk_reg);
                mul_b      = period_reg;
                state_next = ST_JSAVE;
            end
            ST_JSAVE:
            begin
                jstep_next = mul_reg[PAD_W-2:MUL_W];
                ax_next    = 1'b0;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                err_next  = err_x;
                emag_next = err_abs[MAG_W-1:0];
                if (ax_reg)
                    lim_next = accel_yaw_reg;
                else
                    lim_next = speeding ? accel_lin_reg : decel_lin_reg;
                // With a zero period neither axis moves.
                if (period_reg == '0)
                begin
                    ax_next    = 1'b1;
                    state_next = ax_reg ? ST_OUT : ST_PREP;
                end
                else
                begin
                    state_next = ST_ELO;
                end
            end
            ST_ELO:
            begin
                mul_a      = emag_pad[MUL_W-1:0];
                mul_b      = MUL_W'(inv_reg);
                state_next = ST_EHI;
            end
            ST_EHI:
            begin
                acc_next   = ACC_W'(mul_reg);
                mul_a      = emag_pad[PAD_W-1:MUL_W];
                mul_b      = MUL_W'(inv_reg);
                state_next = ST_ESUM;
            end
            ST_ESUM:
            begin
                acc_next   = acc_reg + (ACC_W'(mul_reg) << MUL_W);
                state_next = ST_DESIRE;
            end
            ST_DESIRE:
            begin
                diff_next  = desired - XW'(cur_acc);
                state_next = ST_ACCEL;
            end
            ST_ACCEL:
            begin
                a_next     = a_sat;
                amag_next  = a_abs[VW-1:0];
                state_next = ST_PLO;
            end
            ST_PLO:
            begin
                mul_a      = amag_pad[MUL_W-1:0];
                mul_b      = period_reg;
                state_next = ST_PHI;
            end
            ST_PHI:
            begin
                acc_next   = ACC_W'(mul_reg);
                mul_a      = amag_pad[PAD_W-1:MUL_W];
                mul_b      = period_reg;
                state_next = ST_PSUM;
            end
            ST_PSUM:
            begin
                acc_next   = acc_reg + (ACC_W'(mul_reg) << MUL_W);
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                // The velocity step is truncated on its magnitude, then given its sign.
                prop_next  = (a_reg < 0) ? (XW'(cur_val) - pmag) : (XW'(cur_val) + pmag);
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // Reaching or passing the target snaps onto it and drops the acceleration.
                if (snap)
                begin
                    val_next[ax_reg]   = cur_tgt;
                    accel_next[ax_reg] = '0;
                end
                else
                begin
                    val_next[ax_reg]   = sat_val(prop_reg);
                    accel_next[ax_reg] = a_reg;
                end
                ax_next    = 1'b1;
                state_next = ax_reg ? ST_OUT : ST_PREP;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.linear_out = IO_W'(val_reg[0]);
                    out_next.yaw_out    = IO_W'(val_reg[1]);
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg        <= 1'b0;
            val_reg       <= '{default: '0};
            accel_reg     <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ax_reg        <= ax_next;
            val_reg       <= val_next;
            accel_reg     <= accel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg   <= tgt_next;
        err_reg   <= err_next;
        emag_reg  <= emag_next;
        lim_reg   <= lim_next;
        jstep_reg <= jstep_next;
        acc_reg   <= acc_next;
        diff_reg  <= diff_next;
        a_reg     <= a_next;
        amag_reg  <= amag_next;
        prop_reg  <= prop_next;
        mul_reg   <= mul_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_lin_reg <= RST_MAX_LINEAR_SPEED;
            speed_yaw_reg <= RST_MAX_YAW_RATE;
            accel_lin_reg <= RST_MAX_LINEAR_ACCEL;
            decel_lin_reg <= RST_MAX_LINEAR_DECEL;
            accel_yaw_reg <= RST_MAX_YAW_ACCEL;
            jerk_reg      <= RST_MAX_JERK;
            period_reg    <= RST_STEP_PERIOD;
            inv_reg       <= RST_INVERSE_PERIOD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_LINEAR_SPEED: speed_lin_reg <= cfg_data[LIMIT_W-1:0];
                CFG_MAX_YAW_RATE:     speed_yaw_reg <= cfg_data[LIMIT_W-1:0];
                CFG_MAX_LINEAR_ACCEL: accel_lin_reg <= cfg_data[LIMIT_W-1:0];
                CFG_MAX_LINEAR_DECEL: decel_lin_reg <= cfg_data[LIMIT_W-1:0];
                CFG_MAX_YAW_ACCEL:    accel_yaw_reg <= cfg_data[LIMIT_W-1:0];
                CFG_MAX_JERK:         jerk_reg      <= cfg_data[LIMIT_W-1:0];
                CFG_STEP_PERIOD:      period_reg    <= cfg_data[PERIOD_W-1:0];
                CFG_INVERSE_PERIOD:   inv_reg       <= cfg_data[LIMIT_W-1:0];
                default:              inv_reg       <= inv_reg;
            endcase
        end
    end

    `JLCL_ASSERT_NEXT(a_transfer_leaves_idle, clk, rst_n, in_xfer, state_reg != ST_IDLE)
    `JLCL_ASSERT_NEXT(a_stalled_result_waits, clk, rst_n, (state_reg == ST_OUT) && out_valid_reg && out_stall, state_reg == ST_OUT)
    `JLCL_ASSERT_SAME(a_result_from_out_step, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_OUT))
    `JLCL_ASSERT_NEXT(a_yaw_update_ends_item, clk, rst_n, (state_reg == ST_UPDATE) && ax_reg, state_reg == ST_OUT)

endmodule
